// ----- sv/vff_pkg.sv -----
`timescale 1ns / 1ps
package vff_pkg;

  typedef struct packed {
    logic       emit;
    logic       last;
    logic [7:0] px;
    logic [7:0] py;
    logic [7:0] pz;
  } vff_meta_t;

  typedef enum logic [1:0] {
    REG_EXTENT_X = 2'd0,
    REG_EXTENT_Y = 2'd1,
    REG_EXTENT_Z = 2'd2,
    REG_NONE     = 2'd3
  } vff_reg_t;

  localparam logic [15:0] W_DIAG2   = 16'd46341;
  localparam logic [15:0] W_DIAG3   = 16'd37837;
  localparam logic [19:0] FORCE_MAX = 20'h7FFFF;
  localparam logic [19:0] FORCE_MIN = 20'h80000;

endpackage

// ----- sv/vff_plane_store.sv -----
`timescale 1ns / 1ps
// column of three planes at (y, z): current sample plus planes x-1 and x-2
module vff_plane_store #(
  parameter int SB = 16,
  parameter int AW = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [AW-1:0]        addr,
  input  logic [SB-1:0]        sample,
  output logic                 out_valid,
  output logic [2:0][SB-1:0]   col
);

  logic [2*SB-1:0] mem [0:(1<<AW)-1];
  logic [2*SB-1:0] rdata;
  logic [AW-1:0]   addr_q;
  logic [SB-1:0]   sample_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rdata    <= mem[addr];
      addr_q   <= addr;
      sample_q <= sample;
    end
  end

  // write back from the registered address after the read; consecutive beats never share an address
  always_ff @(posedge clk) begin
    if (en && out_valid) begin
      mem[addr_q] <= {sample_q, rdata[2*SB-1:SB]};
    end
  end

  assign col[0] = sample_q;
  assign col[1] = rdata[2*SB-1:SB];
  assign col[2] = rdata[SB-1:0];

endmodule

// ----- sv/vff_row_store.sv -----
`timescale 1ns / 1ps
// current row plus rows y-1 and y-2 of all three planes at column z
module vff_row_store #(
  parameter int SB = 16,
  parameter int CW = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [CW-1:0]             addr,
  input  logic [2:0][SB-1:0]        col,
  output logic                      out_valid,
  output logic [2:0][2:0][SB-1:0]   win
);

  // word layout: [plane][0] = row y-1, [plane][1] = row y-2
  logic [2:0][1:0][SB-1:0] mem [0:(1<<CW)-1];
  logic [2:0][1:0][SB-1:0] rdata;
  logic [2:0][1:0][SB-1:0] wdata;
  logic [CW-1:0]           addr_q;
  logic [2:0][SB-1:0]      col_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rdata  <= mem[addr];
      addr_q <= addr;
      col_q  <= col;
    end
  end

  always_comb begin
    for (int p = 0; p < 3; p++) begin
      wdata[p][0] = col_q[p];
      wdata[p][1] = rdata[p][0];
    end
  end

  always_ff @(posedge clk) begin
    if (en && out_valid) begin
      mem[addr_q] <= wdata;
    end
  end

  always_comb begin
    for (int p = 0; p < 3; p++) begin
      win[p][0] = col_q[p];
      win[p][1] = rdata[p][0];
      win[p][2] = rdata[p][1];
    end
  end

endmodule

// ----- sv/vff_force.sv -----
`timescale 1ns / 1ps
// z taps, class sums, weighting, rounding and saturation
module vff_force #(
  parameter int SB = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [2:0][2:0][SB-1:0]   win,
  input  vff_pkg::vff_meta_t        in_meta,
  output logic                      out_valid,
  output vff_pkg::vff_meta_t        out_meta,
  output logic [2:0][19:0]          force_v
);

  localparam int SW  = SB + 4;
  localparam int PW  = SW + 17;
  localparam int AW  = SB + 21;

  // index 0 is the newest plane, row or tap, so offset = 1 - index
  logic [2:0][2:0][2:0][SB-1:0] taps;
  logic [5:0]                   vld;
  vff_pkg::vff_meta_t           meta [6];

  logic signed [SW-1:0] s1 [3], s2 [3], s3 [3];
  logic signed [SW-1:0] s1q [3], s2q [3], s3q [3];
  logic signed [SW-1:0] s1r [3];
  logic signed [PW-1:0] p2 [3], p3 [3];
  logic signed [AW-1:0] acc [3];
  logic [AW-1:0]        rnd [3];
  logic [AW-1:0]        mag [3];
  logic [2:0]           neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta[0] <= in_meta;
      for (int i = 1; i < 6; i++) meta[i] <= meta[i-1];
      if (in_valid) begin
        for (int p = 0; p < 3; p++) begin
          for (int r = 0; r < 3; r++) begin
            taps[p][r] <= {taps[p][r][1:0], win[p][r]};
          end
        end
      end
    end
  end

  // centre term cancels: each class is symmetric in every axis
  always_comb begin
    int d [3];
    int nk;
    logic signed [SW-1:0] v;
    for (int c = 0; c < 3; c++) begin
      s1[c] = '0;
      s2[c] = '0;
      s3[c] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          d[0] = 1 - i;
          d[1] = 1 - j;
          d[2] = 1 - k;
          nk = int'(d[0] != 0) + int'(d[1] != 0) + int'(d[2] != 0);
          v = $signed({4'b0, taps[i][j][k]});
          for (int c = 0; c < 3; c++) begin
            if (d[c] != 0) begin
              case (nk)
                1: s1[c] = (d[c] > 0) ? s1[c] + v : s1[c] - v;
                2: s2[c] = (d[c] > 0) ? s2[c] + v : s2[c] - v;
                3: s3[c] = (d[c] > 0) ? s3[c] + v : s3[c] - v;
                default: ;
              endcase
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        s1q[c] <= s1[c];
        s2q[c] <= s2[c];
        s3q[c] <= s3[c];
        s1r[c] <= s1q[c];
        p2[c]  <= s2q[c] * $signed({1'b0, vff_pkg::W_DIAG2});
        p3[c]  <= s3q[c] * $signed({1'b0, vff_pkg::W_DIAG3});
        acc[c] <= AW'($signed({s1r[c], 16'b0})) + AW'(p2[c]) + AW'(p3[c]);
        neg[c] <= acc[c][AW-1];
        // half away from zero: magnitude plus one half, then drop 16 bits
        rnd[c] <= acc[c][AW-1] ? (~acc[c] + AW'(32769)) : (acc[c] + AW'(32768));
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) mag[c] = rnd[c] >> 16;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        if (!neg[c]) begin
          force_v[c] <= (mag[c] > AW'(vff_pkg::FORCE_MAX)) ? vff_pkg::FORCE_MAX : mag[c][19:0];
        end else begin
          force_v[c] <= (mag[c] > AW'(vff_pkg::FORCE_MIN)) ? vff_pkg::FORCE_MIN
                                                           : 20'(-mag[c][19:0]);
        end
      end
    end
  end

  assign out_valid = vld[5];
  assign out_meta  = meta[5];

endmodule

// ----- sv/volume_force_field_stencil.sv -----
`timescale 1ns / 1ps
// channel   dir  handshake               beat
// in        in   in_valid / in_stall     sample
// out       out  out_valid / out_stall   pos_x..z, force_x..z, last_voxel
// cfg       in   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// one sample a cycle while in_stall is low; the sample that completes a window passes
// the plane store read, row store read, six arithmetic stages and output register
// before its force is on the output
// the plane store and row store each do at most one read and one write per cycle; both hold while stalled
// rst clears cursors and valids and sets extents to MAX_EXTENT capped at 256; store contents are not cleared
// a two-entry output buffer absorbs out_stall; in_stall rises only when it is full
module volume_force_field_stencil #(
  parameter int MAX_EXTENT  = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         pos_x,
  output logic [7:0]         pos_y,
  output logic [7:0]         pos_z,
  output logic signed [19:0] force_x,
  output logic signed [19:0] force_y,
  output logic signed [19:0] force_z,
  output logic               last_voxel,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [8:0]         cfg_data
);

  localparam int CW = $clog2(MAX_EXTENT);
  localparam int EW = $clog2(MAX_EXTENT + 1);
  localparam int SB = SAMPLE_BITS;

  logic [EW-1:0] ext_x, ext_y, ext_z;
  logic [CW-1:0] cur_x, cur_y, cur_z;
  logic [CW-1:0] lim_x, lim_y, lim_z;
  logic [CW-1:0] xm1, ym1, zm1;
  logic          en, accept, cfg_hit;
  logic [EW-1:0] cfg_clamped;
  logic [10:0]   cfg_wide;
  logic [SB+15:0] sample_wide;

  vff_pkg::vff_meta_t meta0, meta1, meta2, f_meta;
  logic [2:0][SB-1:0]      col;
  logic [2:0][2:0][SB-1:0] win;
  logic                    pv, rv, fv;
  logic [2:0][19:0]        f_force;

  typedef struct packed {
    vff_pkg::vff_meta_t meta;
    logic [2:0][19:0]   frc;
  } vff_result_t;

  vff_result_t f_res, out_res, skid_res;
  logic        skid_valid, out_take;

  assign en        = !skid_valid;
  assign in_stall  = skid_valid;
  assign accept    = in_valid && en;
  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && (cfg_index != vff_pkg::REG_NONE);

  assign cfg_wide    = {2'b0, cfg_data};
  assign cfg_clamped = (cfg_wide < 11'd3) ? EW'(3) :
                       (cfg_wide > 11'(MAX_EXTENT)) ? EW'(MAX_EXTENT) : EW'(cfg_wide);

  always_ff @(posedge clk) begin
    if (rst) begin
      ext_x <= EW'(MAX_EXTENT < 256 ? MAX_EXTENT : 256);
      ext_y <= EW'(MAX_EXTENT < 256 ? MAX_EXTENT : 256);
      ext_z <= EW'(MAX_EXTENT < 256 ? MAX_EXTENT : 256);
    end else if (cfg_valid) begin
      case (cfg_index)
        vff_pkg::REG_EXTENT_X: ext_x <= cfg_clamped;
        vff_pkg::REG_EXTENT_Y: ext_y <= cfg_clamped;
        vff_pkg::REG_EXTENT_Z: ext_z <= cfg_clamped;
        default: ;
      endcase
    end
  end

  assign lim_x = CW'(ext_x - EW'(1));
  assign lim_y = CW'(ext_y - EW'(1));
  assign lim_z = CW'(ext_z - EW'(1));

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      cur_x <= '0;
      cur_y <= '0;
      cur_z <= '0;
    end else if (accept) begin
      if (cur_z == lim_z) begin
        cur_z <= '0;
        if (cur_y == lim_y) begin
          cur_y <= '0;
          cur_x <= (cur_x == lim_x) ? '0 : cur_x + CW'(1);
        end else begin
          cur_y <= cur_y + CW'(1);
        end
      end else begin
        cur_z <= cur_z + CW'(1);
      end
    end
  end

  assign xm1 = cur_x - CW'(1);
  assign ym1 = cur_y - CW'(1);
  assign zm1 = cur_z - CW'(1);

  always_comb begin
    logic [CW+7:0] tx, ty, tz;
    tx = {8'b0, xm1};
    ty = {8'b0, ym1};
    tz = {8'b0, zm1};
    meta0.emit = (cur_x >= CW'(2)) && (cur_y >= CW'(2)) && (cur_z >= CW'(2));
    meta0.last = (cur_x == lim_x) && (cur_y == lim_y) && (cur_z == lim_z);
    meta0.px   = tx[7:0];
    meta0.py   = ty[7:0];
    meta0.pz   = tz[7:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta1 <= meta0;
      meta2 <= meta1;
    end
  end

  assign sample_wide = {{SB{1'b0}}, sample};

  vff_plane_store #(.SB(SB), .AW(2*CW)) u_plane (
    .clk(clk), .rst(rst), .en(en), .in_valid(accept),
    .addr({cur_y, cur_z}), .sample(sample_wide[SB-1:0]),
    .out_valid(pv), .col(col)
  );

  logic [CW-1:0] z1;
  always_ff @(posedge clk) begin
    if (en) z1 <= cur_z;
  end

  vff_row_store #(.SB(SB), .CW(CW)) u_row (
    .clk(clk), .rst(rst), .en(en), .in_valid(pv), .addr(z1), .col(col),
    .out_valid(rv), .win(win)
  );

  vff_force #(.SB(SB)) u_force (
    .clk(clk), .rst(rst), .en(en), .in_valid(rv), .win(win), .in_meta(meta2),
    .out_valid(fv), .out_meta(f_meta), .force_v(f_force)
  );

  assign f_res.meta = f_meta;
  assign f_res.frc  = f_force;
  assign out_take   = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end
    end else if (fv && f_meta.emit) begin
      if (!out_valid || out_take) begin
        out_res   <= f_res;
        out_valid <= 1'b1;
      end else begin
        skid_res   <= f_res;
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  assign pos_x      = out_res.meta.px;
  assign pos_y      = out_res.meta.py;
  assign pos_z      = out_res.meta.pz;
  assign last_voxel = out_res.meta.last;
  assign force_x    = out_res.frc[0];
  assign force_y    = out_res.frc[1];
  assign force_z    = out_res.frc[2];

  a_skid_has_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a beat while the output register is empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !out_stall |=> !skid_valid)
    else $error("skid beat not moved on a free output");

  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_hit |=> cur_x == '0 && cur_y == '0 && cur_z == '0)
    else $error("register write did not restart the volume");

endmodule
